>>> hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int WIN_N        = 9;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int HEIGHT_CAP     = 4096;
  localparam int MIN_DIM        = 3;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int FIRST_INTERIOR = 2;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Position and frame marker of one result pixel
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pos_t;

  // One window column in ascending order
  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } col3_t;

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col3_t sort3(pix_t a, pix_t b, pix_t c);
    col3_t s;
    s.lo  = min3(a, b, c);
    s.mid = med3(a, b, c);
    s.hi  = max3(a, b, c);
    return s;
  endfunction

endpackage

>>> hw/rtl/mf3_line_store.sv
// ----------------------------------------------------------------------------
// mf3_line_store
// Two row memories holding the two image rows above the incoming pixel.
// One registered read and one write per cycle on each memory.
// ----------------------------------------------------------------------------
module mf3_line_store
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output pix_t          rd_upper_o,
  output pix_t          rd_middle_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  pix_t          wr_upper_i,
  input  pix_t          wr_middle_i
);

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t rd_upper_q;
  pix_t rd_middle_q;

  // Write back the shifted column: middle row moves up, new pixel enters
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
  end

  // Read the column of the incoming pixel; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_upper_q  <= upper_mem[rd_addr_i];
      rd_middle_q <= middle_mem[rd_addr_i];
    end
  end

  assign rd_upper_o  = rd_upper_q;
  assign rd_middle_o = rd_middle_q;

endmodule

>>> hw/rtl/mf3_window.sv
// ----------------------------------------------------------------------------
// mf3_window
// Two stored pixel columns plus the current column form the 3x3 window.
// ----------------------------------------------------------------------------
module mf3_window
  import mf3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic restart_i,
  input  logic shift_i,
  input  pix_t top_i,
  input  pix_t mid_i,
  input  pix_t pixel_i,
  output pix_t win_o [WIN_N]
);

  // Older column in entries 0..2, newer in 3..5 (top, middle, bottom)
  pix_t cols_q [6];

  // Shift in the current column; clear on frame restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) cols_q[i] <= '0;
    end else if (restart_i) begin
      for (int i = 0; i < 6; i++) cols_q[i] <= '0;
    end else if (shift_i) begin
      cols_q[0] <= cols_q[3];
      cols_q[1] <= cols_q[4];
      cols_q[2] <= cols_q[5];
      cols_q[3] <= top_i;
      cols_q[4] <= mid_i;
      cols_q[5] <= pixel_i;
    end
  end

  // Row-major window: top row, middle row, bottom row
  always_comb begin
    win_o[0] = cols_q[0];
    win_o[1] = cols_q[3];
    win_o[2] = top_i;
    win_o[3] = cols_q[1];
    win_o[4] = cols_q[4];
    win_o[5] = mid_i;
    win_o[6] = cols_q[2];
    win_o[7] = cols_q[5];
    win_o[8] = pixel_i;
  end

endmodule

>>> hw/rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage median-of-nine network: sort the three columns, then take the
// median of max-of-lows, median-of-mids and min-of-highs.
// ----------------------------------------------------------------------------
module mf3_median
  import mf3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  pix_t win_i [WIN_N],
  input  pos_t pos_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output pix_t median_o,
  output pos_t pos_o
);

  logic  a_valid_q;
  col3_t a_cols_q [3];
  pos_t  a_pos_q;
  logic  a_ready;

  logic  b_valid_q;
  pix_t  b_median_q;
  pos_t  b_pos_q;
  logic  b_ready;

  pix_t  lo_max;
  pix_t  mid_med;
  pix_t  hi_min;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Stage A valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  // Stage A payload: sort each window column
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        a_cols_q[i] <= sort3(win_i[i], win_i[i + 3], win_i[i + 6]);
      end
      a_pos_q <= pos_i;
    end
  end

  // Combine the sorted columns
  always_comb begin
    lo_max  = max3(a_cols_q[0].lo, a_cols_q[1].lo, a_cols_q[2].lo);
    mid_med = med3(a_cols_q[0].mid, a_cols_q[1].mid, a_cols_q[2].mid);
    hi_min  = min3(a_cols_q[0].hi, a_cols_q[1].hi, a_cols_q[2].hi);
  end

  // Stage B valid: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  // Stage B payload
  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_median_q <= med3(lo_max, mid_med, hi_min);
      b_pos_q    <= a_pos_q;
    end
  end

  assign out_valid_o = b_valid_q;
  assign median_o    = b_median_q;
  assign pos_o       = b_pos_q;

endmodule

>>> hw/rtl/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// Path: a result passes from the edge that accepts its completing pixel (line
//   store read there) through the column sort and median output registers.
// Throughput: one pixel per cycle unless stalled; the output register and ready
//   chain let a pixel enter while a result waits. Border pixels give no result.
// Reset: counters, window and valid flags clear; frame size returns to
//   640x480. The line stores are not cleared; a config write restarts the frame.
// ----------------------------------------------------------------------------
module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      median_value_o,
  output logic [ROW_W-1:0]      center_row_o,
  output logic [COL_W-1:0]      center_col_o,
  output logic                  frame_last_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_CFG_W) ?
                      $clog2(MAX_WIDTH + 1) : WIDTH_CFG_W;
  localparam int W_RESET_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  // Frame geometry and position
  logic [CW-1:0]    wlast_q;
  logic [ROW_W-1:0] hlast_q;
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             restart;
  logic             in_fire;

  logic [WW-1:0]           w_raw, w_eff;
  logic [HEIGHT_CFG_W-1:0] h_raw, h_eff;

  // Line store stage
  logic          s1_valid_q;
  logic          s1_emit_q;
  pix_t          s1_pixel_q;
  logic [CW-1:0] s1_col_q;
  pos_t          s1_pos_q;
  logic          s1_fire;
  pos_t          pos_d;

  pix_t rd_upper, rd_middle;
  pix_t win [WIN_N];

  logic med_ready;
  pix_t med_value;
  pos_t med_pos;

  assign restart = cfg_we_i;

  // Clamp the written size into the supported range
  always_comb begin
    w_raw = WW'(cfg_data_i[WIDTH_CFG_W-1:0]);
    w_eff = w_raw;
    if (w_raw < WW'(MIN_DIM))   w_eff = WW'(MIN_DIM);
    if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    h_raw = cfg_data_i[HEIGHT_CFG_W-1:0];
    h_eff = h_raw;
    if (h_raw < HEIGHT_CFG_W'(MIN_DIM))    h_eff = HEIGHT_CFG_W'(MIN_DIM);
    if (h_raw > HEIGHT_CFG_W'(HEIGHT_CAP)) h_eff = HEIGHT_CFG_W'(HEIGHT_CAP);
  end

  // Hold the last column and row index of the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= CW'(W_RESET_EFF - 1);
      hlast_q <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  wlast_q <= CW'(w_eff - WW'(1));
        REG_IMAGE_HEIGHT: hlast_q <= ROW_W'(h_eff - HEIGHT_CFG_W'(1));
        default: ;
      endcase
    end
  end

  // Advance the raster position of the next pixel
  always_comb begin
    col_d = col_q + CW'(1);
    row_d = row_q;
    if (col_q == wlast_q) begin
      col_d = '0;
      row_d = (row_q == hlast_q) ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Result position for a window centered above-left of this pixel
  always_comb begin
    pos_d.row  = row_q - ROW_W'(1);
    pos_d.col  = COL_W'(col_q - CW'(1));
    pos_d.last = (row_q == hlast_q) && (col_q == wlast_q);
  end

  // Stage 1 handshake: non-emitting pixels leave without waiting
  assign s1_fire    = s1_valid_q && (!s1_emit_q || med_ready);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pixel_q <= pixel_i;
      s1_col_q   <= col_q;
      s1_emit_q  <= (row_q >= ROW_W'(FIRST_INTERIOR)) && (col_q >= CW'(FIRST_INTERIOR));
      s1_pos_q   <= pos_d;
    end
  end

  mf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_addr_i   (col_q),
    .rd_upper_o  (rd_upper),
    .rd_middle_o (rd_middle),
    .wr_en_i     (s1_fire),
    .wr_addr_i   (s1_col_q),
    .wr_upper_i  (rd_middle),
    .wr_middle_i (s1_pixel_q)
  );

  mf3_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .shift_i   (s1_fire),
    .top_i     (rd_upper),
    .mid_i     (rd_middle),
    .pixel_i   (s1_pixel_q),
    .win_o     (win)
  );

  mf3_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q && s1_emit_q),
    .in_ready_o  (med_ready),
    .win_i       (win),
    .pos_i       (s1_pos_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_o    (med_value),
    .pos_o       (med_pos)
  );

  assign median_value_o = med_value;
  assign center_row_o   = med_pos.row;
  assign center_col_o   = med_pos.col;
  assign frame_last_o   = med_pos.last;

endmodule

>>> tb/median_filter_3x3_checker.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_checker
// Passive checker for the 3x3 median filter. Watches register writes and both
// stream channels, tracks its own line stores, window and frame position,
// queues the expected median for each accepted pixel that closes a full window
// and compares each result transaction field by field against the oldest one.
// ----------------------------------------------------------------------------
module median_filter_3x3_checker
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PIX_W-1:0]      median_value_i,
  input  logic [ROW_W-1:0]      center_row_i,
  input  logic [COL_W-1:0]      center_col_i,
  input  logic                  frame_last_i,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam int KEPT_PIXELS = 6;

  typedef struct packed {
    pix_t value;
    pos_t pos;
  } median_result_t;

  pix_t                    upper_line  [MAX_WIDTH];
  pix_t                    middle_line [MAX_WIDTH];
  pix_t                    prev_cols   [KEPT_PIXELS];
  int unsigned             next_col;
  int unsigned             next_row;
  logic [WIDTH_CFG_W-1:0]  width_cfg;
  logic [HEIGHT_CFG_W-1:0] height_cfg;
  median_result_t          median_q [$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Pick the element with at most four smaller and at least five not larger
  function automatic pix_t median_of_nine(pix_t [WIN_N-1:0] v);
    int below;
    int not_above;
    for (int i = 0; i < WIN_N; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < WIN_N; j++) begin
        if (v[j] < v[i]) below++;
        if (v[j] <= v[i]) not_above++;
      end
      if (below <= WIN_N / 2 && not_above > WIN_N / 2) return v[i];
    end
    return '0;
  endfunction

  function automatic void restart_frame();
    foreach (prev_cols[i]) prev_cols[i] = '0;
    next_col = 0;
    next_row = 0;
  endfunction

  // Shift one pixel through line stores and window; flag a result when the
  // pixel closes a full neighborhood
  function automatic bit predict_pixel(input pix_t p, output median_result_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    pix_t             two_up;
    pix_t             one_up;
    pix_t [WIN_N-1:0] nb;
    bit               hit;
    w = clamp_dim(width_cfg, MAX_WIDTH);
    h = clamp_dim(height_cfg, HEIGHT_CAP);
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    two_up = upper_line[c];
    one_up = middle_line[c];
    upper_line[c]  = one_up;
    middle_line[c] = p;
    hit = (r >= FIRST_INTERIOR) && (c >= FIRST_INTERIOR);
    res = '0;
    if (hit) begin
      nb = {prev_cols[0], prev_cols[3], two_up,
            prev_cols[1], prev_cols[4], one_up,
            prev_cols[2], prev_cols[5], p};
      res.value    = median_of_nine(nb);
      res.pos.row  = ROW_W'(r - 1);
      res.pos.col  = COL_W'(c - 1);
      res.pos.last = (r == h - 1) && (c == w - 1);
    end
    prev_cols[0] = prev_cols[3];
    prev_cols[1] = prev_cols[4];
    prev_cols[2] = prev_cols[5];
    prev_cols[3] = two_up;
    prev_cols[4] = one_up;
    prev_cols[5] = p;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
    return hit;
  endfunction

  always @(posedge clk_i) begin : monitor
    median_result_t got;
    median_result_t want;
    bit             hit;
    if (!rst_ni) begin
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      width_cfg  = WIDTH_CFG_W'(WIDTH_RESET);
      height_cfg = HEIGHT_CFG_W'(HEIGHT_RESET);
      restart_frame();
      median_q.delete();
    end else begin
      // Compare a result transaction against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got.value    = median_value_i;
        got.pos.row  = center_row_i;
        got.pos.col  = center_col_i;
        got.pos.last = frame_last_i;
        if (median_q.size() == 0) begin
          if (errors_o < MAX_REPORTS)
            $display("%0t: result with nothing pending: median %0d row %0d col %0d last %0b",
                     $time, got.value, got.pos.row, got.pos.col, got.pos.last);
          errors_o++;
        end else begin
          want = median_q.pop_front();
          if (got.value !== want.value || got.pos.row !== want.pos.row ||
              got.pos.col !== want.pos.col || got.pos.last !== want.pos.last) begin
            if (errors_o < MAX_REPORTS)
              $display({"%0t: mismatch: expected median %0d row %0d col %0d last %0b,",
                        " got median %0d row %0d col %0d last %0b"}, $time,
                       want.value, want.pos.row, want.pos.col, want.pos.last,
                       got.value, got.pos.row, got.pos.col, got.pos.last);
            errors_o++;
          end
        end
      end
      // Any register write restarts the frame
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH:  width_cfg  = cfg_data_i[WIDTH_CFG_W-1:0];
          REG_IMAGE_HEIGHT: height_cfg = cfg_data_i[HEIGHT_CFG_W-1:0];
          default: ;
        endcase
        restart_frame();
      end
      // Predict from each accepted pixel transaction
      if (in_valid_i && in_ready_i) begin
        hit = predict_pixel(pixel_i, want);
        if (hit) median_q.push_back(want);
      end
    end
    pending_o = median_q.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 3x3 median filter. Drives frame sizes through
// the register port and pixel streams through the input channel, with random
// idling on both channels and a long output hold-off; the checker instance
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb
  import mf3_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int LONG_HOLD     = 300;
  localparam int PRESS_ITEMS   = 120;
  localparam int PHASE_ITEMS   = 450;
  localparam int SEG_CAP       = 240;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  typedef enum int {
    PIX_UNIFORM,
    PIX_RAILS,
    PIX_CLUSTER
  } pix_style_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  pix_t                  pixel;
  logic                  out_valid;
  logic                  out_ready;
  pix_t                  median_value;
  logic [ROW_W-1:0]      center_row;
  logic [COL_W-1:0]      center_col;
  logic                  frame_last;
  int                    chk_errors;
  int                    chk_pending;

  int unsigned             send_idle_pct;
  int unsigned             recv_idle_pct;
  int unsigned             hold_requests;
  logic [WIDTH_CFG_W-1:0]  width_now;
  logic [HEIGHT_CFG_W-1:0] height_now;

  always #HALF_PERIOD clk = ~clk;

  median_filter_3x3 dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .median_value_o (median_value),
    .center_row_o   (center_row),
    .center_col_o   (center_col),
    .frame_last_o   (frame_last)
  );

  median_filter_3x3_checker u_median_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .pixel_i        (pixel),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .median_value_i (median_value),
    .center_row_i   (center_row),
    .center_col_i   (center_col),
    .frame_last_i   (frame_last),
    .errors_o       (chk_errors),
    .pending_o      (chk_pending)
  );

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pix_t rand_pixel(pix_style_e style, pix_t base);
    case (style)
      PIX_RAILS:   return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_CLUSTER: return base + pix_t'($urandom_range(2));
      default:     return pix_t'($urandom_range(255));
    endcase
  endfunction

  // Mostly small rows; some out of range on either side, spare bits random
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int unsigned           roll;
    logic [CFG_DATA_W-1:0] d;
    roll = $urandom_range(99);
    d = CFG_DATA_W'($urandom);
    if (roll < 60) d[WIDTH_CFG_W-1:0] = WIDTH_CFG_W'($urandom_range(3, 8));
    else if (roll < 75) d[WIDTH_CFG_W-1:0] = WIDTH_CFG_W'($urandom_range(9, 40));
    else if (roll < 87) d[WIDTH_CFG_W-1:0] = WIDTH_CFG_W'($urandom_range(0, 2));
    else d[WIDTH_CFG_W-1:0] = WIDTH_CFG_W'($urandom_range(DEF_MAX_WIDTH + 1, 2047));
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return CFG_DATA_W'($urandom_range(3, 6));
    if (roll < 80) return CFG_DATA_W'($urandom_range(0, 2));
    if (roll < 90) return CFG_DATA_W'($urandom_range(7, 20));
    if (roll < 95) return CFG_DATA_W'(HEIGHT_CAP);
    return CFG_DATA_W'($urandom_range(HEIGHT_CAP + 1, 8191));
  endfunction

  // Offer one pixel transaction, idling first at the sender's rate
  task automatic send_pixel(input pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then cover pipeline latency
  task automatic settle();
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
    if (idx == REG_IMAGE_WIDTH) width_now = val[WIDTH_CFG_W-1:0];
    else height_now = val[HEIGHT_CFG_W-1:0];
  endtask

  task automatic run_directed();
    pix_t spread [WIN_N];
    pix_t dups   [WIN_N];
    spread = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd2, 8'd253, 8'd129};
    dups   = '{8'd7, 8'd7, 8'd7, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd7};
    // Smallest frame: one interior pixel, which is also the last of the frame
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    foreach (spread[i]) send_pixel(spread[i]);
    // Next frame follows without a write after the counters wrap
    repeat (WIN_N) send_pixel(8'hFF);
    // Sizes below the minimum clamp up; spare width bits are ignored
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'h1802);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    foreach (dups[i]) send_pixel(dups[i]);
    // Tall narrow frame under a long output hold-off: fill up and stall input
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd40);
    hold_requests++;
    repeat (PRESS_ITEMS) send_pixel(rand_pixel(PIX_UNIFORM, '0));
  endtask

  // New size, then whole frames or a frame cut short by the next write
  task automatic run_segment(input bit press, output int unsigned n);
    int unsigned           w;
    int unsigned           h;
    int unsigned           which;
    pix_style_e            style;
    pix_t                  base;
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;
    wv = pick_width();
    hv = pick_height();
    settle();
    which = $urandom_range(2);
    if (which != 1) write_reg(REG_IMAGE_WIDTH, wv);
    if (which != 0) write_reg(REG_IMAGE_HEIGHT, hv);
    w = clamp_dim(width_now, DEF_MAX_WIDTH);
    h = clamp_dim(height_now, HEIGHT_CAP);
    n = $urandom_range(1, 3) * w * h;
    if (n > SEG_CAP)
      n = (3 * w + 40 <= SEG_CAP) ? $urandom_range(3 * w, 3 * w + 40) : $urandom_range(1, 200);
    else if ($urandom_range(3) == 0)
      n = n - $urandom_range(0, w - 1);
    style = pix_style_e'($urandom_range(2));
    base  = pix_t'($urandom_range(253));
    if (press) hold_requests++;
    repeat (n) send_pixel(rand_pixel(style, base));
  endtask

  task automatic run_random_phase();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    run_segment(1'b1, n);
    sent += n;
    while (sent < PHASE_ITEMS) begin
      run_segment(1'b0, n);
      sent += n;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned holds_served;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_IMAGE_WIDTH;
    cfg_data      = '0;
    in_valid      = 1'b0;
    pixel         = '0;
    send_idle_pct = 37;
    recv_idle_pct = 72;
    hold_requests = 0;
    width_now     = WIDTH_CFG_W'(WIDTH_RESET);
    height_now    = HEIGHT_CFG_W'(HEIGHT_RESET);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_random_phase();
    send_idle_pct = 72;
    recv_idle_pct = 37;
    run_random_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase();

    // Drain and watch for stray results
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule
